@@ hdl/mfd_pkg.sv @@
// Shared types, constants and register codes for the motor feedback frame decoder.
`timescale 1ns / 1ps

package mfd_pkg;

    localparam int ID_W       = 11;
    localparam int NUM_CFG    = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int NUM_ENC    = 3;
    localparam int ENC_IDX_W  = 2;
    localparam int SRC_W      = 3;
    localparam int WORD_W     = 16;
    localparam int DIFF_W     = WORD_W + 1;
    localparam int HALF_RANGE = 4096;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic signed [DIFF_W-1:0] HALF_POS = DIFF_W'(HALF_RANGE);
    localparam logic signed [DIFF_W-1:0] HALF_NEG = -HALF_POS;
    localparam logic signed [WORD_W-1:0] TURN_MAX = 16'sh7FFF;
    localparam logic signed [WORD_W-1:0] TURN_MIN = 16'sh8000;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ID_SMALL_A = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ID_SMALL_B = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ID_JOINT_1 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_ID_JOINT_2 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_ID_JOINT_3 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ID_BOARD_0 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_ID_BOARD_1 = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_ID_DRIVE   = 3'd7;

    // Identifier defaults after reset
    localparam logic [ID_W-1:0] RST_ID_SMALL_A = 11'd513;
    localparam logic [ID_W-1:0] RST_ID_SMALL_B = 11'd514;
    localparam logic [ID_W-1:0] RST_ID_JOINT_1 = 11'd17;
    localparam logic [ID_W-1:0] RST_ID_JOINT_2 = 11'd18;
    localparam logic [ID_W-1:0] RST_ID_JOINT_3 = 11'd19;
    localparam logic [ID_W-1:0] RST_ID_BOARD_0 = 11'd257;
    localparam logic [ID_W-1:0] RST_ID_BOARD_1 = 11'd258;
    localparam logic [ID_W-1:0] RST_ID_DRIVE   = 11'd513;

    // Source codes
    localparam logic [SRC_W-1:0] SRC_SMALL_A = 3'd0;
    localparam logic [SRC_W-1:0] SRC_SMALL_B = 3'd1;
    localparam logic [SRC_W-1:0] SRC_DRIVE   = 3'd2;
    localparam logic [SRC_W-1:0] SRC_JOINT_1 = 3'd3;
    localparam logic [SRC_W-1:0] SRC_JOINT_2 = 3'd4;
    localparam logic [SRC_W-1:0] SRC_JOINT_3 = 3'd5;
    localparam logic [SRC_W-1:0] SRC_BOARD_0 = 3'd6;
    localparam logic [SRC_W-1:0] SRC_BOARD_1 = 3'd7;

    typedef logic [7:0][7:0] t_bytes;

    typedef struct packed {
        logic             matched;
        logic [SRC_W-1:0] source;
        t_bytes           bytes;
    } t_frame_item;

    typedef struct packed {
        logic                     matched;
        logic [SRC_W-1:0]         source;
        logic [WORD_W-1:0]        word_a;
        logic [WORD_W-1:0]        word_b;
        logic [WORD_W-1:0]        word_c;
        logic [WORD_W-1:0]        word_d;
        logic [7:0]               temperature;
        logic signed [WORD_W-1:0] turn_count;
        logic [3:0]               status_nibble;
        logic [3:0]               reply_id;
    } t_result;

    typedef struct packed {
        logic push;
        logic pop;
    } t_queue_ctrl;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

endpackage

@@ hdl/mfd_front.sv @@
// Front stage: identifier registers and source classification of incoming frames.
`timescale 1ns / 1ps

module mfd_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic [mfd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [mfd_pkg::ID_W-1:0]       i_cfg_data,
    input  logic                           i_bus_select,
    input  logic [mfd_pkg::ID_W-1:0]       i_frame_id,
    input  mfd_pkg::t_bytes                i_bytes,
    output mfd_pkg::t_frame_item           o_item
);

    logic [mfd_pkg::ID_W-1:0] r_cfg_id [mfd_pkg::NUM_CFG];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_id[mfd_pkg::CFG_ID_SMALL_A] <= mfd_pkg::RST_ID_SMALL_A;
            r_cfg_id[mfd_pkg::CFG_ID_SMALL_B] <= mfd_pkg::RST_ID_SMALL_B;
            r_cfg_id[mfd_pkg::CFG_ID_JOINT_1] <= mfd_pkg::RST_ID_JOINT_1;
            r_cfg_id[mfd_pkg::CFG_ID_JOINT_2] <= mfd_pkg::RST_ID_JOINT_2;
            r_cfg_id[mfd_pkg::CFG_ID_JOINT_3] <= mfd_pkg::RST_ID_JOINT_3;
            r_cfg_id[mfd_pkg::CFG_ID_BOARD_0] <= mfd_pkg::RST_ID_BOARD_0;
            r_cfg_id[mfd_pkg::CFG_ID_BOARD_1] <= mfd_pkg::RST_ID_BOARD_1;
            r_cfg_id[mfd_pkg::CFG_ID_DRIVE]   <= mfd_pkg::RST_ID_DRIVE;
        end else if (i_cfg_valid) begin
            r_cfg_id[i_cfg_index] <= i_cfg_data;
        end
    end

    // First hit in list order wins when two identifiers on one bus are equal
    always_comb begin
        o_item.bytes   = i_bytes;
        o_item.matched = 1'b1;
        o_item.source  = mfd_pkg::SRC_SMALL_A;
        if (!i_bus_select) begin
            if (i_frame_id == r_cfg_id[mfd_pkg::CFG_ID_SMALL_A]) begin
                o_item.source = mfd_pkg::SRC_SMALL_A;
            end else if (i_frame_id == r_cfg_id[mfd_pkg::CFG_ID_SMALL_B]) begin
                o_item.source = mfd_pkg::SRC_SMALL_B;
            end else if (i_frame_id == r_cfg_id[mfd_pkg::CFG_ID_JOINT_1]) begin
                o_item.source = mfd_pkg::SRC_JOINT_1;
            end else if (i_frame_id == r_cfg_id[mfd_pkg::CFG_ID_JOINT_2]) begin
                o_item.source = mfd_pkg::SRC_JOINT_2;
            end else if (i_frame_id == r_cfg_id[mfd_pkg::CFG_ID_JOINT_3]) begin
                o_item.source = mfd_pkg::SRC_JOINT_3;
            end else begin
                o_item.matched = 1'b0;
            end
        end else begin
            if (i_frame_id == r_cfg_id[mfd_pkg::CFG_ID_BOARD_0]) begin
                o_item.source = mfd_pkg::SRC_BOARD_0;
            end else if (i_frame_id == r_cfg_id[mfd_pkg::CFG_ID_BOARD_1]) begin
                o_item.source = mfd_pkg::SRC_BOARD_1;
            end else if (i_frame_id == r_cfg_id[mfd_pkg::CFG_ID_DRIVE]) begin
                o_item.source = mfd_pkg::SRC_DRIVE;
            end else begin
                o_item.matched = 1'b0;
            end
        end
    end

endmodule

@@ hdl/mfd_queue.sv @@
// Short queue of classified frames between the front and back stages.
`timescale 1ns / 1ps

module mfd_queue (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  mfd_pkg::t_queue_ctrl   i_ctrl,
    input  mfd_pkg::t_frame_item   i_item,
    output mfd_pkg::t_frame_item   o_item,
    output mfd_pkg::t_queue_status o_status
);

    mfd_pkg::t_frame_item             r_mem [mfd_pkg::QUEUE_DEPTH];
    logic [mfd_pkg::QPTR_W-1:0]       r_wr_ptr;
    logic [mfd_pkg::QPTR_W-1:0]       r_rd_ptr;
    logic [mfd_pkg::QCNT_W-1:0]       r_count;
    logic                             w_push;
    logic                             w_pop;

    assign o_status.full  = (r_count == mfd_pkg::QCNT_W'(mfd_pkg::QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign w_push = i_ctrl.push && !o_status.full;
    assign w_pop  = i_ctrl.pop && !o_status.empty;
    assign o_item = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == mfd_pkg::QPTR_W'(mfd_pkg::QUEUE_DEPTH - 1)) ?
                            '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == mfd_pkg::QPTR_W'(mfd_pkg::QUEUE_DEPTH - 1)) ?
                            '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

@@ hdl/mfd_back.sv @@
// Back stage: payload unpacking, turn counting and the result register.
`timescale 1ns / 1ps

module mfd_back (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  mfd_pkg::t_frame_item i_item,
    input  logic                 i_valid,
    output logic                 o_take,
    input  logic                 i_pop,
    output logic                 o_empty,
    output mfd_pkg::t_result     o_result
);

    logic [mfd_pkg::WORD_W-1:0]        r_last_angle   [mfd_pkg::NUM_ENC];
    logic signed [mfd_pkg::WORD_W-1:0] r_turn_counter [mfd_pkg::NUM_ENC];
    logic                              r_out_valid;
    mfd_pkg::t_result                  r_result;
    mfd_pkg::t_result                  n_result;

    logic                              w_is_enc;
    logic [mfd_pkg::ENC_IDX_W-1:0]     w_enc_idx;
    logic [mfd_pkg::WORD_W-1:0]        w_angle;
    logic [mfd_pkg::WORD_W-1:0]        w_cur_last;
    logic signed [mfd_pkg::WORD_W-1:0] w_cur_cnt;
    logic signed [mfd_pkg::WORD_W-1:0] n_cnt;
    logic signed [mfd_pkg::DIFF_W-1:0] w_diff;
    mfd_pkg::t_bytes                   w_b;

    assign w_b       = i_item.bytes;
    assign w_enc_idx = i_item.source[mfd_pkg::ENC_IDX_W-1:0];
    assign w_is_enc  = i_item.matched &&
                       (i_item.source == mfd_pkg::SRC_SMALL_A ||
                        i_item.source == mfd_pkg::SRC_SMALL_B ||
                        i_item.source == mfd_pkg::SRC_DRIVE);
    assign w_angle   = {w_b[0], w_b[1]};

    // Take a new frame when the result slot is free or being emptied
    assign o_take   = i_valid && (!r_out_valid || i_pop);
    assign o_empty  = !r_out_valid;
    assign o_result = r_result;

    always_comb begin
        w_cur_last = '0;
        w_cur_cnt  = '0;
        case (w_enc_idx)
            2'd0: begin
                w_cur_last = r_last_angle[0];
                w_cur_cnt  = r_turn_counter[0];
            end
            2'd1: begin
                w_cur_last = r_last_angle[1];
                w_cur_cnt  = r_turn_counter[1];
            end
            2'd2: begin
                w_cur_last = r_last_angle[2];
                w_cur_cnt  = r_turn_counter[2];
            end
            default: begin
                w_cur_last = '0;
                w_cur_cnt  = '0;
            end
        endcase
    end

    assign w_diff = $signed({1'b0, w_angle}) - $signed({1'b0, w_cur_last});

    // Large forward jump wraps backward a turn, large backward jump wraps forward
    always_comb begin
        n_cnt = w_cur_cnt;
        if (w_diff > mfd_pkg::HALF_POS) begin
            if (w_cur_cnt != mfd_pkg::TURN_MIN) begin
                n_cnt = w_cur_cnt - 16'sd1;
            end
        end else if (w_diff < mfd_pkg::HALF_NEG) begin
            if (w_cur_cnt != mfd_pkg::TURN_MAX) begin
                n_cnt = w_cur_cnt + 16'sd1;
            end
        end
    end

    always_comb begin
        n_result = '0;
        if (i_item.matched) begin
            n_result.matched = 1'b1;
            n_result.source  = i_item.source;
            unique case (i_item.source) inside
                mfd_pkg::SRC_SMALL_A, mfd_pkg::SRC_SMALL_B, mfd_pkg::SRC_DRIVE: begin
                    n_result.word_a      = w_angle;
                    n_result.word_b      = {w_b[2], w_b[3]};
                    n_result.word_c      = {w_b[4], w_b[5]};
                    n_result.temperature = w_b[6];
                    n_result.turn_count  = n_cnt;
                end
                mfd_pkg::SRC_JOINT_1, mfd_pkg::SRC_JOINT_2, mfd_pkg::SRC_JOINT_3: begin
                    n_result.word_a        = {w_b[1], w_b[2]};
                    n_result.word_b        = {4'h0, w_b[3], w_b[4][7:4]};
                    n_result.word_c        = {4'h0, w_b[4][3:0], w_b[5]};
                    n_result.status_nibble = w_b[0][7:4];
                    n_result.reply_id      = w_b[0][3:0];
                end
                mfd_pkg::SRC_BOARD_0, mfd_pkg::SRC_BOARD_1: begin
                    n_result.word_a = {w_b[0], w_b[1]};
                    n_result.word_b = {w_b[2], w_b[3]};
                    n_result.word_c = {w_b[4], w_b[5]};
                    n_result.word_d = {w_b[6], w_b[7]};
                end
                default: begin
                    n_result.word_a = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_result <= n_result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            for (int k = 0; k < mfd_pkg::NUM_ENC; k++) begin
                r_last_angle[k]   <= '0;
                r_turn_counter[k] <= '0;
            end
        end else begin
            if (o_take) begin
                r_out_valid <= 1'b1;
                if (w_is_enc) begin
                    r_last_angle[w_enc_idx]   <= w_angle;
                    r_turn_counter[w_enc_idx] <= n_cnt;
                end
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

@@ hdl/motor_feedback_frame_decoder.sv @@
// Top level of the motor feedback frame decoder: front classifier, queue, back decoder.
//
//  channel   | handshake                    | payload
//  ----------+------------------------------+----------------------------------------
//  frame in  | i_push / o_full              | i_bus_select, i_frame_id, i_data_byte_*
//  result    | o_empty / i_pop              | o_matched .. o_reply_id
//  config    | i_cfg_valid / o_cfg_ready    | i_cfg_index, i_cfg_data
//
//  One frame per cycle sustained while each result is popped; a frame is written into
//  the two-entry queue, then lands in the back stage result slot once that slot is free.
//  Reset: queue and result slot empty, identifiers at defaults, angles and counters zero.
//  A stalled result holds the back stage; the queue then fills and raises o_full.
//  Configuration writes are always ready.
`timescale 1ns / 1ps

module motor_feedback_frame_decoder (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [mfd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [mfd_pkg::ID_W-1:0]      i_cfg_data,
    input  logic                          i_push,
    output logic                          o_full,
    input  logic                          i_bus_select,
    input  logic [mfd_pkg::ID_W-1:0]      i_frame_id,
    input  logic [7:0]                    i_data_byte_0,
    input  logic [7:0]                    i_data_byte_1,
    input  logic [7:0]                    i_data_byte_2,
    input  logic [7:0]                    i_data_byte_3,
    input  logic [7:0]                    i_data_byte_4,
    input  logic [7:0]                    i_data_byte_5,
    input  logic [7:0]                    i_data_byte_6,
    input  logic [7:0]                    i_data_byte_7,
    output logic                          o_empty,
    input  logic                          i_pop,
    output logic                          o_matched,
    output logic [mfd_pkg::SRC_W-1:0]     o_source,
    output logic [mfd_pkg::WORD_W-1:0]    o_word_a,
    output logic [mfd_pkg::WORD_W-1:0]    o_word_b,
    output logic [mfd_pkg::WORD_W-1:0]    o_word_c,
    output logic [mfd_pkg::WORD_W-1:0]    o_word_d,
    output logic [7:0]                    o_temperature,
    output logic signed [mfd_pkg::WORD_W-1:0] o_turn_count,
    output logic [3:0]                    o_status_nibble,
    output logic [3:0]                    o_reply_id
);

    mfd_pkg::t_bytes        w_bytes;
    mfd_pkg::t_frame_item   w_front_item;
    mfd_pkg::t_frame_item   w_back_item;
    mfd_pkg::t_queue_ctrl   w_q_ctrl;
    mfd_pkg::t_queue_status w_q_status;
    mfd_pkg::t_result       w_result;
    logic                   w_take;

    assign o_cfg_ready = 1'b1;

    assign w_bytes[0] = i_data_byte_0;
    assign w_bytes[1] = i_data_byte_1;
    assign w_bytes[2] = i_data_byte_2;
    assign w_bytes[3] = i_data_byte_3;
    assign w_bytes[4] = i_data_byte_4;
    assign w_bytes[5] = i_data_byte_5;
    assign w_bytes[6] = i_data_byte_6;
    assign w_bytes[7] = i_data_byte_7;

    mfd_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_bus_select (i_bus_select),
        .i_frame_id   (i_frame_id),
        .i_bytes      (w_bytes),
        .o_item       (w_front_item)
    );

    assign w_q_ctrl.push = i_push;
    assign w_q_ctrl.pop  = w_take;
    assign o_full        = w_q_status.full;

    mfd_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_ctrl   (w_q_ctrl),
        .i_item   (w_front_item),
        .o_item   (w_back_item),
        .o_status (w_q_status)
    );

    mfd_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (w_back_item),
        .i_valid  (!w_q_status.empty),
        .o_take   (w_take),
        .i_pop    (i_pop),
        .o_empty  (o_empty),
        .o_result (w_result)
    );

    assign o_matched       = w_result.matched;
    assign o_source        = w_result.source;
    assign o_word_a        = w_result.word_a;
    assign o_word_b        = w_result.word_b;
    assign o_word_c        = w_result.word_c;
    assign o_word_d        = w_result.word_d;
    assign o_temperature   = w_result.temperature;
    assign o_turn_count    = w_result.turn_count;
    assign o_status_nibble = w_result.status_nibble;
    assign o_reply_id      = w_result.reply_id;

`ifndef SYNTHESIS
    // A queued frame with a free result slot shows up as a result on the next cycle
    a_queue_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!w_q_status.empty && (o_empty || i_pop)) |=> !o_empty)
        else $error("queued frame did not reach the result slot");

    // Only encoder motors carry a nonzero turn count
    a_turn_only_enc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_turn_count != 16'sd0) |->
        (o_matched && (o_source == mfd_pkg::SRC_SMALL_A ||
                       o_source == mfd_pkg::SRC_SMALL_B ||
                       o_source == mfd_pkg::SRC_DRIVE)))
        else $error("turn count on a non-encoder result");

    // Unmatched frames give an all-zero result
    a_unmatched_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && !o_matched) |->
        (o_source == '0 && o_word_a == '0 && o_word_b == '0 && o_word_c == '0 &&
         o_word_d == '0 && o_temperature == '0 && o_reply_id == '0))
        else $error("unmatched result carries data");
`endif

endmodule
